// File: src/ddo_pkg.sv
// Shared types, constants and helper functions for the differential drive odometry core.
`default_nettype none

package ddo_pkg;

    localparam int VEL_W      = 12;
    localparam int TSTEP_W    = 24;
    localparam int SPEED_W    = 24;
    localparam int AXLE_W     = 16;
    localparam int HEAD_W     = 19;
    localparam int POS_W      = 32;
    localparam int FRAC_W     = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXLE_LENGTH = 8'd1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd41843;
    localparam logic [AXLE_W-1:0]  AXLE_RESET  = 16'd9830;

    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 62;
    localparam int DIST_W     = 36;
    localparam int HI_W       = DIST_W - MUL_A_W;
    localparam int SDIST_W    = 38;
    localparam int DIVD_W     = 53;
    localparam int MOD_W      = 19;
    localparam int RND_SHIFT  = 24;
    localparam int DELTA_W    = ACC_W + 1 - RND_SHIFT;
    localparam int PSUM_W     = DELTA_W + 1;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W = 5;
    localparam int CORDIC_W   = 34;
    localparam int Z_SHIFT    = 14;
    localparam int TRIG_SHIFT = 6;
    localparam int TRIG_W     = 26;
    localparam int TMAG_W     = 25;

    localparam logic signed [HEAD_W-1:0] PI_Q16          = 19'sd205888;
    localparam logic signed [HEAD_W-1:0] HALF_PI_Q16     = 19'sd102944;
    localparam logic signed [HEAD_W-1:0] NEG_HALF_PI_Q16 = -19'sd102944;
    localparam logic [MOD_W-1:0]         TWO_PI_Q16      = 19'd411776;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] TRIG_RND    = 34'sd32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LO,
        ST_HI,
        ST_WSUM,
        ST_DIFF,
        ST_DSTART,
        ST_DIV,
        ST_ANGLE,
        ST_CSTART,
        ST_CORDIC,
        ST_TLO,
        ST_THI,
        ST_TSUM,
        ST_TRND,
        ST_TPOS,
        ST_OUT
    } ddo_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } ddo_div_state_t;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_RUN,
        COR_ROUND,
        COR_DONE
    } ddo_cor_state_t;

    function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h3243F6A8;
            5'd1:    val = 32'h1DAC6705;
            5'd2:    val = 32'h0FADBAFC;
            5'd3:    val = 32'h07F56EA6;
            5'd4:    val = 32'h03FEAB76;
            5'd5:    val = 32'h01FFD55B;
            5'd6:    val = 32'h00FFFAAA;
            5'd7:    val = 32'h007FFF55;
            5'd8:    val = 32'h003FFFEA;
            5'd9:    val = 32'h001FFFFD;
            5'd10:   val = 32'h000FFFFF;
            5'd11:   val = 32'h0007FFFF;
            5'd12:   val = 32'h0003FFFF;
            5'd13:   val = 32'h0001FFFF;
            5'd14:   val = 32'h0000FFFF;
            5'd15:   val = 32'h00007FFF;
            5'd16:   val = 32'h00003FFF;
            5'd17:   val = 32'h00001FFF;
            5'd18:   val = 32'h00000FFF;
            5'd19:   val = 32'h000007FF;
            5'd20:   val = 32'h000003FF;
            5'd21:   val = 32'h000001FF;
            5'd22:   val = 32'h000000FF;
            5'd23:   val = 32'h0000007F;
            5'd24:   val = 32'h0000003F;
            5'd25:   val = 32'h0000001F;
            5'd26:   val = 32'h0000000F;
            5'd27:   val = 32'h00000007;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    // Adds a reduced offset to a wrapped heading and wraps the sum back to [-pi, pi).
    function automatic logic signed [HEAD_W-1:0] wrap_add(
        input logic signed [HEAD_W-1:0] base,
        input logic [MOD_W-1:0]         off,
        input logic                     neg
    );
        logic signed [HEAD_W+2:0] offs;
        logic signed [HEAD_W+2:0] pi_ext;
        logic signed [HEAD_W+2:0] period;
        logic signed [HEAD_W+2:0] r;
        offs   = $signed({3'b000, off});
        pi_ext = $signed({{3{PI_Q16[HEAD_W-1]}}, PI_Q16});
        period = $signed({3'b000, TWO_PI_Q16});
        if (neg)
        begin
            offs = -offs;
        end
        r = $signed({{3{base[HEAD_W-1]}}, base}) + offs + pi_ext;
        if (r < 0)
        begin
            r = r + period;
        end
        else if (r >= period)
        begin
            r = r - period;
        end
        r = r - pi_ext;
        return r[HEAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/ddo_ifs.sv
// Handshake channel interfaces for the input, result and configuration words.
`default_nettype none

interface ddo_in_if;
    import ddo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VEL_W-1:0]   vel_left;
    logic signed [VEL_W-1:0]   vel_right;
    logic [TSTEP_W-1:0]        time_step;

    modport source (output valid, output vel_left, output vel_right, output time_step,
                    input ready);
    modport sink (input valid, input vel_left, input vel_right, input time_step,
                  output ready);
endinterface

interface ddo_out_if;
    import ddo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;

    modport source (output valid, output heading, output pos_x, output pos_y,
                    input ready);
    modport sink (input valid, input heading, input pos_x, input pos_y,
                  output ready);
endinterface

interface ddo_cfg_if;
    import ddo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/ddo_div.sv
// Bit-serial restoring divider that returns the quotient and half quotient modulo two pi.
`default_nettype none

module ddo_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ddo_pkg::DIVD_W-1:0]  dividend,
    input  logic [ddo_pkg::AXLE_W-1:0]  divisor,
    output logic                        done,
    output logic [ddo_pkg::MOD_W-1:0]   quo_mod,
    output logic [ddo_pkg::MOD_W-1:0]   half_mod
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVD_W - 1);

    ddo_div_state_t state_reg;
    ddo_div_state_t state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DIVD_W-1:0] dvd_reg;
    logic [AXLE_W-1:0] dvs_reg;
    logic [AXLE_W-1:0] rem_reg;
    logic [MOD_W-1:0]  qm_reg;
    logic [MOD_W-1:0]  hm_reg;
    logic [AXLE_W:0]   rem_sh;
    logic [AXLE_W:0]   rem_sub;
    logic              q_bit;
    logic [MOD_W:0]    qm_sh;
    logic [MOD_W:0]    qm_red;
    logic              load;
    logic              run;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load = 1'b0;
        run  = 1'b0;
        done = 1'b0;
        case (state_reg)
            DIV_IDLE: load = start;
            DIV_RUN:  run  = 1'b1;
            DIV_DONE: done = 1'b1;
            default:  load = 1'b0;
        endcase
    end

    // Each step brings one dividend bit into the remainder and one quotient bit
    // into the running residue of the quotient.
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});
        qm_sh   = {qm_reg, q_bit};
        qm_red  = (qm_sh >= {1'b0, TWO_PI_Q16}) ? (qm_sh - {1'b0, TWO_PI_Q16}) : qm_sh;
        cnt_next = load ? '0 : (run ? cnt_reg + 1'b1 : cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
            dvs_reg <= (divisor == '0) ? AXLE_W'(1) : divisor;
            rem_reg <= '0;
            qm_reg  <= '0;
            hm_reg  <= '0;
        end
        else if (run)
        begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= q_bit ? rem_sub[AXLE_W-1:0] : rem_sh[AXLE_W-1:0];
            hm_reg  <= qm_reg;
            qm_reg  <= qm_red[MOD_W-1:0];
        end
    end

    assign quo_mod  = qm_reg;
    assign half_mod = hm_reg;

endmodule

`default_nettype wire

// File: src/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a heading in Q24.
`default_nettype none

module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ddo_pkg::HEAD_W-1:0]  angle,
    output logic                               done,
    output logic signed [ddo_pkg::TRIG_W-1:0]  cos_val,
    output logic signed [ddo_pkg::TRIG_W-1:0]  sin_val
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    ddo_cor_state_t state_reg;
    ddo_cor_state_t state_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic                       flip_reg;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W-1:0]   sin_reg;
    logic signed [HEAD_W-1:0]   ang_adj;
    logic                       flip_in;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] at;
    logic signed [CORDIC_W-1:0] xf;
    logic signed [CORDIC_W-1:0] yf;
    logic signed [CORDIC_W-1:0] xr;
    logic signed [CORDIC_W-1:0] yr;
    logic                       load;
    logic                       run;
    logic                       round;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            COR_IDLE:
            begin
                if (start)
                begin
                    state_next = COR_RUN;
                end
            end
            COR_RUN:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = COR_ROUND;
                end
            end
            COR_ROUND:
            begin
                state_next = COR_DONE;
            end
            COR_DONE:
            begin
                state_next = COR_IDLE;
            end
            default:
            begin
                state_next = COR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load  = 1'b0;
        run   = 1'b0;
        round = 1'b0;
        done  = 1'b0;
        case (state_reg)
            COR_IDLE:  load  = start;
            COR_RUN:   run   = 1'b1;
            COR_ROUND: round = 1'b1;
            COR_DONE:  done  = 1'b1;
            default:   load  = 1'b0;
        endcase
    end

    // Angles beyond a quarter turn are moved by pi and the results negated.
    always_comb
    begin
        flip_in = 1'b0;
        ang_adj = angle;
        if (angle >= HALF_PI_Q16)
        begin
            ang_adj = angle - PI_Q16;
            flip_in = 1'b1;
        end
        else if (angle < NEG_HALF_PI_Q16)
        begin
            ang_adj = angle + PI_Q16;
            flip_in = 1'b1;
        end
        z_init = $signed({{(CORDIC_W - HEAD_W - Z_SHIFT){ang_adj[HEAD_W-1]}}, ang_adj,
                          {Z_SHIFT{1'b0}}});

        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        at = $signed({{(CORDIC_W - 32){1'b0}}, atan_q30(ATAN_IDX_W'(cnt_reg))});

        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        xr = (xf + TRIG_RND) >>> TRIG_SHIFT;
        yr = (yf + TRIG_RND) >>> TRIG_SHIFT;

        cnt_next = load ? '0 : (run ? cnt_reg + 1'b1 : cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= COR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip_in;
        end
        else if (run)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (round)
        begin
            cos_reg <= xr[TRIG_W-1:0];
            sin_reg <= yr[TRIG_W-1:0];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// File: src/differential_drive_odometry_core.sv
// Top level of the differential drive odometry core: sequencer, shared multiplier and pose.
// A new input word is taken only in the idle state, after the last result word is committed;
// one input word is in flight at a time.
// The heading path runs a 53-step bit-serial divide and then the CORDIC loop; the ten
// multiplications share one registered 24 x 25 bit multiplier.
// Reset clears the pose to zero and loads the configuration registers with their defaults.
`default_nettype none

module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ddo_in_if.sink    in_word,
    ddo_out_if.source out_word,
    ddo_cfg_if.sink   cfg
);
    import ddo_pkg::*;

    ddo_state_t state_reg;
    ddo_state_t state_next;

    logic [SPEED_W-1:0]        speed_reg;
    logic [AXLE_W-1:0]         axle_reg;
    logic                      side_reg;
    logic signed [HEAD_W-1:0]  pose_h_reg;
    logic signed [POS_W-1:0]   pose_x_reg;
    logic signed [POS_W-1:0]   pose_y_reg;
    logic                      out_valid_reg;

    logic [VEL_W-1:0]          mag_l_reg;
    logic [VEL_W-1:0]          mag_r_reg;
    logic                      neg_l_reg;
    logic                      neg_r_reg;
    logic [TSTEP_W-1:0]        t_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [HI_W-1:0]           hi_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [DIST_W-1:0]         dl_mag_reg;
    logic [DIST_W-1:0]         dr_mag_reg;
    logic signed [SDIST_W-1:0] diff_reg;
    logic signed [SDIST_W-1:0] sum_reg;
    logic                      dneg_reg;
    logic [DIST_W-1:0]         mean_mag_reg;
    logic                      mean_neg_reg;
    logic signed [HEAD_W-1:0]  mid_reg;
    logic signed [HEAD_W-1:0]  head_new_reg;
    logic [TMAG_W-1:0]         cos_mag_reg;
    logic [TMAG_W-1:0]         sin_mag_reg;
    logic                      cos_neg_reg;
    logic                      sin_neg_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [POS_W-1:0]   x_new_reg;
    logic signed [POS_W-1:0]   y_new_reg;

    logic                      in_acc;
    logic                      in_ready;
    logic                      commit;
    logic                      div_start;
    logic                      cor_start;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [VEL_W-1:0]          cur_mag;
    logic [TMAG_W-1:0]         cur_tmag;
    logic [VEL_W-1:0]          vl_mag;
    logic [VEL_W-1:0]          vr_mag;
    logic [ACC_W-1:0]          wide_sum;
    logic signed [SDIST_W-1:0] sl;
    logic signed [SDIST_W-1:0] sr;
    logic [SDIST_W-1:0]        dmag;
    logic [SDIST_W-1:0]        smag;
    logic [DIVD_W-1:0]         dividend;
    logic signed [ACC_W:0]     disp;
    logic signed [ACC_W:0]     disp_rnd;
    logic signed [PSUM_W-1:0]  pos_sum;
    logic signed [POS_W-1:0]   pos_sat;
    logic signed [POS_W-1:0]   cur_pos;
    logic                      div_done;
    logic [MOD_W-1:0]          quo_mod;
    logic [MOD_W-1:0]          half_mod;
    logic                      cor_done;
    logic signed [TRIG_W-1:0]  cos_val;
    logic signed [TRIG_W-1:0]  sin_val;
    logic [TRIG_W-1:0]         cos_abs;
    logic [TRIG_W-1:0]         sin_abs;

    ddo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (axle_reg),
        .done     (div_done),
        .quo_mod  (quo_mod),
        .half_mod (half_mod)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (mid_reg),
        .done    (cor_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign in_acc = in_word.valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_LO;
            ST_LO:     state_next = ST_HI;
            ST_HI:     state_next = ST_WSUM;
            ST_WSUM:   state_next = side_reg ? ST_DIFF : ST_SCALE;
            ST_DIFF:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:  state_next = ST_CSTART;
            ST_CSTART: state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (cor_done)
                begin
                    state_next = ST_TLO;
                end
            end
            ST_TLO:    state_next = ST_THI;
            ST_THI:    state_next = ST_TSUM;
            ST_TSUM:   state_next = ST_TRND;
            ST_TRND:   state_next = ST_TPOS;
            ST_TPOS:   state_next = side_reg ? ST_OUT : ST_TLO;
            ST_OUT:
            begin
                if (!out_valid_reg || out_word.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cur_mag   = side_reg ? mag_r_reg : mag_l_reg;
        cur_tmag  = side_reg ? sin_mag_reg : cos_mag_reg;
        in_ready  = 1'b0;
        commit    = 1'b0;
        div_start = 1'b0;
        cor_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_SCALE:
            begin
                mul_a = speed_reg;
                mul_b = MUL_B_W'(cur_mag);
            end
            ST_LO:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_W'(prod_reg[MUL_A_W-1:0]);
            end
            ST_HI:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_W'(hi_reg);
            end
            ST_DSTART: div_start = 1'b1;
            ST_CSTART: cor_start = 1'b1;
            ST_TLO:
            begin
                mul_a = mean_mag_reg[MUL_A_W-1:0];
                mul_b = cur_tmag;
            end
            ST_THI:
            begin
                mul_a = MUL_A_W'(mean_mag_reg[DIST_W-1:MUL_A_W]);
                mul_b = cur_tmag;
            end
            ST_OUT:    commit = !out_valid_reg || out_word.ready;
            default:   in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        vl_mag   = in_word.vel_left[VEL_W-1] ? (~in_word.vel_left + 1'b1) : in_word.vel_left;
        vr_mag   = in_word.vel_right[VEL_W-1] ? (~in_word.vel_right + 1'b1) :
                   in_word.vel_right;
        wide_sum = (side_reg && (state_reg == ST_TSUM || state_reg == ST_WSUM)) ||
                   !side_reg ? acc_reg + (ACC_W'(prod_reg) << MUL_A_W) : acc_reg;

        sl = $signed({{(SDIST_W - DIST_W){1'b0}}, dl_mag_reg});
        sr = $signed({{(SDIST_W - DIST_W){1'b0}}, dr_mag_reg});
        if (neg_l_reg)
        begin
            sl = -sl;
        end
        if (neg_r_reg)
        begin
            sr = -sr;
        end

        dmag     = diff_reg[SDIST_W-1] ? $unsigned(-diff_reg) : $unsigned(diff_reg);
        smag     = sum_reg[SDIST_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
        dividend = {dmag[DIVD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

        cos_abs = cos_val[TRIG_W-1] ? $unsigned(-cos_val) : $unsigned(cos_val);
        sin_abs = sin_val[TRIG_W-1] ? $unsigned(-sin_val) : $unsigned(sin_val);

        // Signed displacement, rounded to nearest with ties toward plus infinity.
        disp = $signed({1'b0, acc_reg});
        if (mean_neg_reg ^ (side_reg ? sin_neg_reg : cos_neg_reg))
        begin
            disp = -disp;
        end
        disp_rnd = disp + $signed((ACC_W + 1)'(1) << (RND_SHIFT - 1));

        cur_pos = side_reg ? pose_y_reg : pose_x_reg;
        pos_sum = $signed({{(PSUM_W - POS_W){cur_pos[POS_W-1]}}, cur_pos}) +
                  $signed({delta_reg[DELTA_W-1], delta_reg});
        if (pos_sum[PSUM_W-1:POS_W-1] == '0 || pos_sum[PSUM_W-1:POS_W-1] == '1)
        begin
            pos_sat = pos_sum[POS_W-1:0];
        end
        else if (pos_sum[PSUM_W-1])
        begin
            pos_sat = {1'b1, {(POS_W - 1){1'b0}}};
        end
        else
        begin
            pos_sat = {1'b0, {(POS_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            speed_reg     <= SPEED_RESET;
            axle_reg      <= AXLE_RESET;
            side_reg      <= 1'b0;
            pose_h_reg    <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_SPEED_SCALE: speed_reg <= cfg.data[SPEED_W-1:0];
                    REG_AXLE_LENGTH: axle_reg  <= cfg.data[AXLE_W-1:0];
                    default:         speed_reg <= speed_reg;
                endcase
            end
            if (in_acc)
            begin
                side_reg <= 1'b0;
            end
            else if (state_reg == ST_WSUM || state_reg == ST_TPOS)
            begin
                side_reg <= ~side_reg;
            end
            if (commit)
            begin
                pose_h_reg    <= head_new_reg;
                pose_x_reg    <= x_new_reg;
                pose_y_reg    <= y_new_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mag_l_reg <= vl_mag;
                    mag_r_reg <= vr_mag;
                    neg_l_reg <= in_word.vel_left[VEL_W-1];
                    neg_r_reg <= in_word.vel_right[VEL_W-1];
                    t_reg     <= in_word.time_step;
                end
            end
            ST_LO:
            begin
                hi_reg <= prod_reg[DIST_W-1:MUL_A_W];
            end
            ST_HI:
            begin
                acc_reg <= ACC_W'(prod_reg) + (ACC_W'(1) << (RND_SHIFT - 1));
            end
            ST_WSUM:
            begin
                if (side_reg)
                begin
                    dr_mag_reg <= wide_sum[RND_SHIFT +: DIST_W];
                end
                else
                begin
                    dl_mag_reg <= wide_sum[RND_SHIFT +: DIST_W];
                end
            end
            ST_DIFF:
            begin
                diff_reg <= sr - sl;
                sum_reg  <= sl + sr;
            end
            ST_DSTART:
            begin
                dneg_reg     <= diff_reg[SDIST_W-1];
                mean_mag_reg <= smag[DIST_W:1];
                mean_neg_reg <= sum_reg[SDIST_W-1];
            end
            ST_ANGLE:
            begin
                mid_reg      <= wrap_add(pose_h_reg, half_mod, dneg_reg);
                head_new_reg <= wrap_add(pose_h_reg, quo_mod, dneg_reg);
            end
            ST_CORDIC:
            begin
                if (cor_done)
                begin
                    cos_mag_reg <= cos_abs[TMAG_W-1:0];
                    sin_mag_reg <= sin_abs[TMAG_W-1:0];
                    cos_neg_reg <= cos_val[TRIG_W-1];
                    sin_neg_reg <= sin_val[TRIG_W-1];
                end
            end
            ST_THI:
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            ST_TSUM:
            begin
                acc_reg <= wide_sum;
            end
            ST_TRND:
            begin
                delta_reg <= disp_rnd[ACC_W:RND_SHIFT];
            end
            ST_TPOS:
            begin
                if (side_reg)
                begin
                    y_new_reg <= pos_sat;
                end
                else
                begin
                    x_new_reg <= pos_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_word.ready    = in_ready;
    assign cfg.ready        = 1'b1;
    assign out_word.valid   = out_valid_reg;
    assign out_word.heading = pose_h_reg;
    assign out_word.pos_x   = pose_x_reg;
    assign out_word.pos_y   = pose_y_reg;

endmodule

`default_nettype wire

// File: tb/sv/differential_drive_odometry_core_tb.sv
// Self-checking testbench for the odometry core: pose prediction, handshake traffic, config phases.
module differential_drive_odometry_core_tb;
    import ddo_pkg::*;

    localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;

    localparam longint HALF_TURN    = 205888;
    localparam longint FULL_TURN    = 411776;
    localparam longint QUARTER_TURN = 102944;
    localparam longint START_GAIN   = 652032874;
    localparam longint POS_MAX      = 2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    typedef struct {
        logic signed [VEL_W-1:0] vel_left;
        logic signed [VEL_W-1:0] vel_right;
        logic [TSTEP_W-1:0]      time_step;
    } wheel_sample_t;

    typedef struct {
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ddo_in_if  in_word_if ();
    ddo_out_if out_word_if ();
    ddo_cfg_if cfg_if ();

    differential_drive_odometry_core #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word_if),
        .out_word(out_word_if),
        .cfg     (cfg_if)
    );

    wheel_sample_t pending_samples[$];
    pose_t         expected_poses[$];

    logic [SPEED_W-1:0] scale_reg = SPEED_RESET;
    logic [AXLE_W-1:0]  axle_reg  = AXLE_RESET;
    longint heading_state = 0;
    longint x_state = 0;
    longint y_state = 0;

    longint arctan_q30 [0:30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
        64'h00000000
    };

    int  snd_idle_pct = 0;
    int  rcv_idle_pct = 0;
    int  fault_count = 0;
    bit  in_sent = 1'b0;

    always #5 clk = ~clk;

    function automatic longint wheel_travel(input logic signed [VEL_W-1:0] vel,
                                            input logic [TSTEP_W-1:0] t);
        longint          v;
        longint unsigned mag;
        longint unsigned prod;
        longint          d;
        v = vel;
        mag = (v < 0) ? -v : v;
        prod = mag * scale_reg * t;
        d = longint'((prod + 64'd8388608) >> 24);
        return (v < 0) ? -d : d;
    endfunction

    function automatic longint wrap_heading(input longint a);
        longint r;
        r = (a + HALF_TURN) % FULL_TURN;
        if (r < 0)
        begin
            r += FULL_TURN;
        end
        return r - HALF_TURN;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX)
        begin
            return POS_MAX;
        end
        if (v < POS_MIN)
        begin
            return POS_MIN;
        end
        return v;
    endfunction

    task automatic advance_pose(input wheel_sample_t s);
        longint          dl;
        longint          dr;
        longint          axle;
        longint          diff;
        longint unsigned dmag;
        longint          dtheta;
        longint          mid;
        longint          mean;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          c24;
        longint          s24;
        bit              flip;
        int              steps;
        int              i;
        pose_t           p;
        dl = wheel_travel(s.vel_left, s.time_step);
        dr = wheel_travel(s.vel_right, s.time_step);
        axle = (axle_reg == 0) ? 1 : longint'(axle_reg);
        diff = dr - dl;
        dmag = (diff < 0) ? -diff : diff;
        dtheta = longint'((dmag << 16) / axle);
        if (diff < 0)
        begin
            dtheta = -dtheta;
        end
        mid = wrap_heading(heading_state + dtheta / 2);
        mean = (dl + dr) / 2;

        // The rotation only converges within a quarter turn, so fold the angle by a half turn.
        flip = 1'b0;
        if (mid >= QUARTER_TURN)
        begin
            mid -= HALF_TURN;
            flip = 1'b1;
        end
        else if (mid < -QUARTER_TURN)
        begin
            mid += HALF_TURN;
            flip = 1'b1;
        end
        x = START_GAIN;
        y = 0;
        z = mid * 16384;
        steps = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
        for (i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_q30[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_q30[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c24 = (x + 32) >>> 6;
        s24 = (y + 32) >>> 6;

        heading_state = wrap_heading(heading_state + dtheta);
        x_state = clamp_pos(x_state + ((mean * c24 + 64'sd8388608) >>> 24));
        y_state = clamp_pos(y_state + ((mean * s24 + 64'sd8388608) >>> 24));
        p.heading = heading_state[HEAD_W-1:0];
        p.pos_x = x_state[POS_W-1:0];
        p.pos_y = y_state[POS_W-1:0];
        expected_poses.insert(expected_poses.size(), p);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_word_if.valid && in_word_if.ready)
        begin
            advance_pose('{in_word_if.vel_left, in_word_if.vel_right, in_word_if.time_step});
            in_sent = 1'b1;
        end
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_if.index)
                REG_SPEED_SCALE: scale_reg = cfg_if.data[SPEED_W-1:0];
                REG_AXLE_LENGTH: axle_reg = cfg_if.data[AXLE_W-1:0];
                default: ;
            endcase
        end
    end

    always @(negedge clk)
    begin
        wheel_sample_t s;
        if (!in_word_if.valid || in_sent)
        begin
            in_sent = 1'b0;
            if (pending_samples.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                s = pending_samples.pop_front();
                in_word_if.valid <= 1'b1;
                in_word_if.vel_left <= s.vel_left;
                in_word_if.vel_right <= s.vel_right;
                in_word_if.time_step <= s.time_step;
            end
            else
            begin
                in_word_if.valid <= 1'b0;
            end
        end
        out_word_if.ready <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && out_word_if.valid && out_word_if.ready)
        begin
            if (expected_poses.size() == 0)
            begin
                $error("result word with no pose pending");
                fault_count++;
            end
            else
            begin
                p = expected_poses.pop_front();
                if (out_word_if.heading !== p.heading)
                begin
                    $error("heading mismatch: expected %0d, actual %0d",
                           p.heading, out_word_if.heading);
                    fault_count++;
                end
                if (out_word_if.pos_x !== p.pos_x)
                begin
                    $error("pos_x mismatch: expected %0d, actual %0d",
                           p.pos_x, out_word_if.pos_x);
                    fault_count++;
                end
                if (out_word_if.pos_y !== p.pos_y)
                begin
                    $error("pos_y mismatch: expected %0d, actual %0d",
                           p.pos_y, out_word_if.pos_y);
                    fault_count++;
                end
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic signed [VEL_W-1:0] vl,
                                input logic signed [VEL_W-1:0] vr,
                                input logic [TSTEP_W-1:0] t);
        pending_samples.insert(pending_samples.size(), '{vl, vr, t});
    endtask

    function automatic logic signed [VEL_W-1:0] random_velocity();
        if ($urandom_range(3) == 0)
        begin
            return $urandom_range(1) ? 12'sd2047 : -12'sd2048;
        end
        return VEL_W'($urandom_range(4095));
    endfunction

    task automatic queue_random_samples(input int count);
        logic [TSTEP_W-1:0] t;
        int                 n;
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(7))
                0: t = TSTEP_W'($urandom_range(24'hFFFFFF));
                1: t = TSTEP_W'($urandom_range(15));
                default: t = TSTEP_W'($urandom_range(16383));
            endcase
            queue_sample(random_velocity(), random_velocity(), t);
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_word_if.valid || expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [SPEED_W-1:0] scale, input logic [AXLE_W-1:0] axle,
                             input int count, input int snd_pct, input int rcv_pct);
        write_register(REG_SPEED_SCALE, scale);
        write_register(REG_AXLE_LENGTH, {8'h00, axle});
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        queue_random_samples(count);
        wait_drained();
    endtask

    initial
    begin
        in_word_if.valid = 1'b0;
        in_word_if.vel_left = '0;
        in_word_if.vel_right = '0;
        in_word_if.time_step = '0;
        out_word_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Writes to unmapped indexes must leave both registers at their defaults.
        write_register(REG_UNUSED_LO, 24'hFFFFFF);
        write_register(REG_UNUSED_HI, 24'h000001);
        snd_idle_pct = 29;
        rcv_idle_pct = 65;
        queue_sample(12'sd0, 12'sd0, 24'd0);
        queue_sample(12'sd2047, 12'sd2047, 24'd0);
        queue_sample(12'sd2047, 12'sd2047, 24'd65536);
        queue_sample(-12'sd2048, -12'sd2048, 24'd65536);
        queue_sample(12'sd2047, -12'sd2048, 24'd65536);
        queue_sample(-12'sd2048, 12'sd2047, 24'd65536);
        queue_sample(12'sd1, -12'sd1, 24'd1);
        queue_sample(-12'sd1, 12'sd1, 24'd1);
        queue_sample(-12'sd2048, 12'sd2047, 24'hFFFFFF);
        queue_sample(12'sd2047, -12'sd2048, 24'hFFFFFF);
        repeat (3) queue_sample(12'sd2047, 12'sd2047, 24'hFFFFFF);
        repeat (3) queue_sample(-12'sd2048, -12'sd2048, 24'hFFFFFF);
        wait_drained();

        run_phase(SPEED_RESET, AXLE_RESET, 215, 29, 65);
        run_phase(24'hFFFFFF, 16'd1, 215, 29, 65);
        run_phase(24'd0, 16'hFFFF, 215, 29, 65);
        run_phase(SPEED_W'($urandom_range(24'hFFFFFF)), 16'd0, 215, 65, 29);
        run_phase(SPEED_W'($urandom_range(24'hFFFFFF)), AXLE_W'($urandom_range(65535, 1)),
                  215, 65, 29);
        run_phase(24'hFFFFFF, 16'hFFFF, 215, 65, 29);
        run_phase(SPEED_RESET, AXLE_RESET, 215, 0, 0);
        run_phase(SPEED_W'($urandom_range(24'hFFFFFF)), 16'd1, 215, 0, 0);
        run_phase(SPEED_W'($urandom_range(24'hFFFFFF)), AXLE_W'($urandom_range(65535, 1)),
                  215, 0, 0);

        repeat (200) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
